/* design/lce_pkg.sv */
// Shared types, constants and helpers of the console line editor.
package lce_pkg;

    localparam int LINE_BYTES  = 32;
    localparam int LEN_W       = $clog2(LINE_BYTES);
    localparam int TAB_STOP    = 8;
    localparam int TAB_BITS    = $clog2(TAB_STOP);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_W       = 5;
    localparam int MAX_ARGS    = 16;

    localparam logic [7:0] KEY_ETX   = 8'h03;
    localparam logic [7:0] KEY_NAK   = 8'h15;
    localparam logic [7:0] KEY_ETB   = 8'h17;
    localparam logic [7:0] KEY_BS    = 8'h08;
    localparam logic [7:0] KEY_DEL   = 8'h7F;
    localparam logic [7:0] KEY_CR    = 8'h0D;
    localparam logic [7:0] KEY_LF    = 8'h0A;
    localparam logic [7:0] KEY_TAB   = 8'h09;
    localparam logic [7:0] KEY_SPACE = 8'h20;

    localparam logic [1:0] CFG_EDIT   = 2'd0;
    localparam logic [1:0] CFG_MAXARG = 2'd1;
    localparam logic [1:0] CFG_PROMPT = 2'd2;

    typedef enum logic [2:0] {
        KIND_ECHO    = 3'd0,
        KIND_SPACES  = 3'd1,
        KIND_ERASE   = 3'd2,
        KIND_BELL    = 3'd3,
        KIND_NEWLINE = 3'd4,
        KIND_LINE    = 3'd5,
        KIND_ABORT   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        CLS_CHAR  = 3'd0,
        CLS_ENTER = 3'd1,
        CLS_ABORT = 3'd2,
        CLS_KILL  = 3'd3,
        CLS_WORD  = 3'd4,
        CLS_DEL   = 3'd5
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] key;
    } req_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
        logic [7:0] run;
        logic       start;
        logic [4:0] num;
        logic       outside;
        logic       many;
        logic       last;
    } res_t;

    typedef struct packed {
        logic       edit;
        logic [4:0] max_args;
        logic [2:0] prompt;
    } cfg_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == KEY_SPACE) || (c == KEY_TAB);
    endfunction

endpackage

/* design/lce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/lce_front.sv */
// Front end: classifies key bytes and queues the requests for the back end.
module lce_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          key_valid,
    output logic          key_stall,
    input  logic [7:0]    key_byte,
    output logic          q_valid,
    output lce_pkg::req_t q_data,
    input  logic          q_pop
);
    import lce_pkg::*;

    req_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;
    req_t              req;

    always_comb
    begin
        req.key = key_byte;
        case (key_byte)
            KEY_CR, KEY_LF:  req.cls = CLS_ENTER;
            KEY_ETX:         req.cls = CLS_ABORT;
            KEY_NAK:         req.cls = CLS_KILL;
            KEY_ETB:         req.cls = CLS_WORD;
            KEY_BS, KEY_DEL: req.cls = CLS_DEL;
            default:         req.cls = CLS_CHAR;
        endcase
    end

    assign key_stall = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push      = key_valid && !key_stall;
    assign q_valid   = (count_reg != '0);
    assign q_data    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/lce_back.sv */
// Back end: executes queued requests against the line store and emits results.
module lce_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lce_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  lce_pkg::req_t q_data,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_stall,
    output lce_pkg::res_t res
);
    import lce_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_EXEC   = 15'h0002,
        ST_CNT_RD = 15'h0004,
        ST_CNT_US = 15'h0008,
        ST_NL     = 15'h0010,
        ST_LN_RD  = 15'h0020,
        ST_LN_US  = 15'h0040,
        ST_WD_RD  = 15'h0080,
        ST_WD_US  = 15'h0100,
        ST_BS_RD  = 15'h0200,
        ST_BS_US  = 15'h0400,
        ST_ERASE  = 15'h0800,
        ST_RT_RD  = 15'h1000,
        ST_RT_US  = 15'h2000,
        ST_DONE   = 15'h4000
    } state_t;

    state_t           state_reg, state_next;
    req_t             cur_reg, cur_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       col_reg, col_next;
    logic [4:0]       total_reg, total_next;
    logic [4:0]       nargs_reg, nargs_next;
    logic             inarg_reg, inarg_next;
    logic             stopped_reg, stopped_next;
    res_t             pend_reg, pend_next;
    logic             pend_vld_reg, pend_vld_next;
    res_t             out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    logic             emit;
    res_t             em;
    logic             can_push;
    logic             out_free;
    logic             we;
    logic [LEN_W-1:0] raddr;
    logic [7:0]       rdata;
    logic [7:0]       echo_c;
    logic [7:0]       echo_run;
    logic [8:0]       col_sum;
    logic [7:0]       col_echo;
    logic [7:0]       prompt_col;
    logic [4:0]       maxa;
    logic             many;
    logic             last_idx;
    logic             ws;

    lce_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(len_reg),
        .wdata(cur_reg.key),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Delete paths read the last character; the walks read at the index.
    assign raddr = (state_reg == ST_WD_RD || state_reg == ST_WD_US ||
                    state_reg == ST_BS_RD || state_reg == ST_BS_US)
                   ? len_reg - 1'b1 : idx_reg;

    assign out_free   = !out_vld_reg || !res_stall;
    assign can_push   = !pend_vld_reg || out_free;
    assign prompt_col = {5'd0, cfg.prompt};
    assign maxa       = (cfg.max_args > 5'(MAX_ARGS)) ? 5'(MAX_ARGS) : cfg.max_args;
    assign many       = (total_reg > maxa);
    assign last_idx   = (idx_reg == len_reg - 1'b1);
    assign ws         = is_space(rdata);

    // Echo of one character: a tab advances to the next tab stop.
    assign echo_c   = (state_reg == ST_RT_US) ? rdata : cur_reg.key;
    assign echo_run = (echo_c == KEY_TAB)
                      ? 8'(TAB_STOP) - 8'(col_reg[TAB_BITS-1:0]) : 8'd1;
    assign col_sum  = {1'b0, col_reg} + {1'b0, echo_run};
    assign col_echo = col_sum[8] ? 8'hFF : col_sum[7:0];

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        col_next     = col_reg;
        total_next   = total_reg;
        nargs_next   = nargs_reg;
        inarg_next   = inarg_reg;
        stopped_next = stopped_reg;
        q_pop        = 1'b0;
        we           = 1'b0;
        emit         = 1'b0;
        em           = '0;
        em.kind      = KIND_ECHO;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cur_reg.cls)
                    CLS_CHAR:
                    begin
                        emit = 1'b1;
                        if (len_reg < LEN_W'(LINE_BYTES - 2))
                        begin
                            if (cur_reg.key == KEY_TAB)
                            begin
                                em.kind = KIND_SPACES;
                                em.run  = echo_run;
                            end
                            else
                            begin
                                em.kind = KIND_ECHO;
                                em.chr  = cur_reg.key;
                            end
                            col_next = col_echo;
                            we       = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            em.kind = KIND_BELL;
                        end
                    end
                    CLS_ENTER:
                    begin
                        idx_next   = '0;
                        total_next = '0;
                        inarg_next = 1'b0;
                        state_next = (len_reg == '0) ? ST_NL : ST_CNT_RD;
                    end
                    CLS_ABORT:
                    begin
                        emit     = 1'b1;
                        em.kind  = KIND_ABORT;
                        len_next = '0;
                        col_next = prompt_col;
                    end
                    CLS_KILL:
                    begin
                        if (cfg.edit)
                        begin
                            emit     = (col_reg > prompt_col);
                            em.kind  = KIND_ERASE;
                            em.run   = col_reg - prompt_col;
                            col_next = prompt_col;
                            len_next = '0;
                        end
                    end
                    CLS_WORD, CLS_DEL:
                    begin
                        if (cfg.edit)
                        begin
                            if (len_reg == '0)
                            begin
                                emit    = 1'b1;
                                em.kind = KIND_BELL;
                            end
                            else
                            begin
                                state_next = (cur_reg.cls == CLS_WORD) ? ST_WD_RD : ST_BS_RD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CNT_RD: state_next = ST_CNT_US;
            ST_CNT_US:
            begin
                if (!ws && !inarg_reg)
                begin
                    total_next = total_reg + 1'b1;
                end
                inarg_next = !ws;
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? ST_NL : ST_CNT_RD;
            end
            ST_NL:
            begin
                emit         = 1'b1;
                em.kind      = KIND_NEWLINE;
                em.many      = many;
                idx_next     = '0;
                nargs_next   = '0;
                inarg_next   = 1'b0;
                stopped_next = 1'b0;
                if (len_reg == '0)
                begin
                    col_next   = prompt_col;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LN_RD;
                end
            end
            ST_LN_RD: state_next = ST_LN_US;
            ST_LN_US:
            begin
                emit    = 1'b1;
                em.kind = KIND_LINE;
                em.chr  = rdata;
                em.many = many;
                if (ws)
                begin
                    inarg_next = 1'b0;
                    em.num     = stopped_reg ? maxa : nargs_reg;
                    em.outside = 1'b1;
                end
                else if (!inarg_reg && !stopped_reg && nargs_reg < maxa)
                begin
                    em.start   = 1'b1;
                    em.num     = nargs_reg;
                    nargs_next = nargs_reg + 1'b1;
                    inarg_next = 1'b1;
                end
                else if (!inarg_reg || stopped_reg)
                begin
                    stopped_next = 1'b1;
                    em.num       = maxa;
                    em.outside   = 1'b1;
                end
                else
                begin
                    em.num = nargs_reg - 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    len_next   = '0;
                    col_next   = prompt_col;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LN_RD;
                end
            end
            ST_WD_RD: state_next = ST_WD_US;
            ST_WD_US:
            begin
                len_next   = len_reg - 1'b1;
                state_next = (len_reg != LEN_W'(1) && rdata != KEY_SPACE) ? ST_WD_RD : ST_ERASE;
            end
            ST_BS_RD: state_next = ST_BS_US;
            ST_BS_US:
            begin
                len_next = len_reg - 1'b1;
                if (rdata == KEY_TAB)
                begin
                    state_next = ST_ERASE;
                end
                else
                begin
                    emit       = 1'b1;
                    em.kind    = KIND_ERASE;
                    em.run     = 8'd1;
                    col_next   = (col_reg != 8'd0) ? col_reg - 1'b1 : col_reg;
                    state_next = ST_DONE;
                end
            end
            ST_ERASE:
            begin
                emit       = (col_reg > prompt_col);
                em.kind    = KIND_ERASE;
                em.run     = col_reg - prompt_col;
                col_next   = prompt_col;
                idx_next   = '0;
                state_next = (len_reg == '0) ? ST_DONE : ST_RT_RD;
            end
            ST_RT_RD: state_next = ST_RT_US;
            ST_RT_US:
            begin
                emit = 1'b1;
                if (rdata == KEY_TAB)
                begin
                    em.kind = KIND_SPACES;
                    em.run  = echo_run;
                end
                else
                begin
                    em.kind = KIND_ECHO;
                    em.chr  = rdata;
                end
                col_next   = col_echo;
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? ST_DONE : ST_RT_RD;
            end
            ST_DONE:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Hold everything while a result cannot be taken.
        if (emit && !can_push)
        begin
            state_next   = state_reg;
            len_next     = len_reg;
            idx_next     = idx_reg;
            col_next     = col_reg;
            total_next   = total_reg;
            nargs_next   = nargs_reg;
            inarg_next   = inarg_reg;
            stopped_next = stopped_reg;
            we           = 1'b0;
        end
    end

    // One result is held back so that the last one of a request can be marked.
    always_comb
    begin
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && res_stall;
        if (emit && can_push)
        begin
            pend_next     = em;
            pend_vld_next = 1'b1;
            if (pend_vld_reg)
            begin
                out_next      = pend_reg;
                out_next.last = 1'b0;
                out_vld_next  = 1'b1;
            end
        end
        else if (state_reg == ST_DONE && pend_vld_reg && out_free)
        begin
            out_next      = pend_reg;
            out_next.last = 1'b1;
            out_vld_next  = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        nargs_reg   <= nargs_next;
        inarg_reg   <= inarg_next;
        stopped_reg <= stopped_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            col_reg      <= 8'd2;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            col_reg      <= col_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

/* design/console_line_editor_unit.sv */
// Console line editor: top level with configuration registers and both halves.
//
// Key bytes enter through a four-request queue, so typing is stalled only when
// the queue is full. Every read of the line store takes an address state and
// then a registered-data state; backspace on a plain character reads it once,
// a retype reads each character, and Enter walks the store twice. At most one
// result leaves per cycle, and each request's final result is released once
// the request has finished, with last_result set. The line store is a
// 32-byte RAM; the echo column resets to two prompt columns.
module console_line_editor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    input  logic [7:0] key_byte,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] result_kind,
    output logic [7:0] char_value,
    output logic [7:0] run_count,
    output logic       argument_start,
    output logic [4:0] argument_number,
    output logic       outside_argument,
    output logic       too_many_arguments,
    output logic       last_result
);
    import lce_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    req_t q_data;
    logic q_pop;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edit     <= 1'b1;
            cfg_reg.max_args <= 5'd8;
            cfg_reg.prompt   <= 3'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EDIT:   cfg_reg.edit     <= cfg_data[0];
                CFG_MAXARG: cfg_reg.max_args <= cfg_data;
                CFG_PROMPT: cfg_reg.prompt   <= cfg_data[2:0];
                default:    cfg_reg          <= cfg_reg;
            endcase
        end
    end

    lce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_byte (key_byte),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    lce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    assign result_kind        = res.kind;
    assign char_value         = res.chr;
    assign run_count          = res.run;
    assign argument_start     = res.start;
    assign argument_number    = res.num;
    assign outside_argument   = res.outside;
    assign too_many_arguments = res.many;
    assign last_result        = res.last;

endmodule
